FILE: design/assert_macros.svh
// Assertion helpers included by buddy_allocator_best_fit.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/bafit_pkg.sv
package bafit_pkg;

    // Operation codes.
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_NO_TAG   = 2'd2;
    localparam logic [1:0] ST_BAD_SIZE = 2'd3;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_SPLIT,
        S_MERGE_RD,
        S_MERGE_CHK,
        S_OUT
    } state_t;

endpackage

FILE: design/buddy_allocator_best_fit.sv
// Buddy allocator whose block table sits in one synchronous RAM with one entry per unit.
// An allocate scans all 2^order entries, picks a block and then splits once a cycle;
// a release scans up to 2^order entries for the tag and merges one level at a time,
// reading the buddy in S_MERGE_RD and checking it in S_MERGE_CHK. One request at a time.
// Reset (aresetn low, synchronous) sets memory_order to 6 and clears the table;
// a configuration write does the same.
`include "assert_macros.svh"

module buddy_allocator_best_fit #(
    parameter int TOTAL_UNITS = 64,
    parameter int TAG_WIDTH   = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // operation[0], tag[8:1], request_size[15:9]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // status[1:0], block_offset[7:2], block_size[14:8]
);

    localparam int AW = (TOTAL_UNITS > 1) ? $clog2(TOTAL_UNITS) : 1;
    localparam int CAP = $clog2(TOTAL_UNITS + 1) - 1;
    localparam int OW = 5;
    localparam int TW = TAG_WIDTH;
    // Entry: tag, order, free, start.
    localparam int EW = TW + OW + 2;

    bafit_pkg::state_t state_reg, state_next;

    logic [2:0]    order_cfg_reg;
    logic [OW-1:0] ord_eff;
    logic [AW:0]   idx_reg, idx_next;
    logic [AW:0]   mem_size;
    logic          op_reg;
    logic [TW-1:0] tag_reg;
    logic [6:0]    req_reg;
    logic          found_reg, found_next;
    logic [AW-1:0] pick_reg, pick_next;
    logic [OW-1:0] pord_reg, pord_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [OW-1:0] cord_reg, cord_next;
    logic [AW-1:0] rd_addr_q_reg;
    logic [1:0]    st_reg, st_next;
    logic [5:0]    off_reg, off_next;
    logic [6:0]    sz_reg, sz_next;
    logic          mvalid_reg;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic          e_start, e_free;
    logic [OW-1:0] e_ord;
    logic [TW-1:0] e_tag;
    logic [AW:0]   half;
    logic [AW-1:0] bud;

    assign e_start = rdata[0];
    assign e_free  = rdata[1];
    assign e_ord   = rdata[OW+1:2];
    assign e_tag   = rdata[EW-1:OW+2];

    // Effective order is clamped to the table size.
    always_comb begin
        if (32'(order_cfg_reg) > CAP) begin
            ord_eff = OW'(CAP);
        end else begin
            ord_eff = OW'(order_cfg_reg);
        end
    end
    assign mem_size = (AW+1)'(1) << ord_eff;

    bafit_ram #(.WIDTH(EW), .DEPTH(TOTAL_UNITS)) u_table (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign s_tready = (state_reg == bafit_pkg::S_IDLE) && !mvalid_reg && !cfg_we;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {1'b0, sz_reg, off_reg, st_reg};

    // Sequencer: next state, table access and result.
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        pick_next  = pick_reg;
        pord_next  = pord_reg;
        cur_next   = cur_reg;
        cord_next  = cord_reg;
        st_next    = st_reg;
        off_next   = off_reg;
        sz_next    = sz_reg;
        we         = 1'b0;
        waddr      = '0;
        wdata      = '0;
        raddr      = idx_reg[AW-1:0];
        half       = '0;
        bud        = '0;
        case (state_reg)
            bafit_pkg::S_CLEAR: begin
                we    = 1'b1;
                waddr = idx_reg[AW-1:0];
                if (idx_reg == '0) begin
                    wdata = {{TW{1'b0}}, ord_eff, 2'b11};
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == (AW+1)'(TOTAL_UNITS - 1)) begin
                    state_next = bafit_pkg::S_IDLE;
                end
            end
            bafit_pkg::S_IDLE: begin
                idx_next   = '0;
                found_next = 1'b0;
                raddr      = '0;
                if (s_tvalid && s_tready) begin
                    if (s_tdata[0] == bafit_pkg::OP_ALLOC && s_tdata[15:9] == 7'd0) begin
                        st_next    = bafit_pkg::ST_BAD_SIZE;
                        off_next   = '0;
                        sz_next    = '0;
                        state_next = bafit_pkg::S_OUT;
                    end else begin
                        idx_next   = (AW+1)'(1);
                        state_next = bafit_pkg::S_SCAN;
                    end
                end
            end
            bafit_pkg::S_SCAN: begin
                // rdata holds the entry at rd_addr_q_reg; idx_reg is the next address.
                if (op_reg == bafit_pkg::OP_ALLOC) begin
                    if (e_start && e_free && ({25'd0, 7'd1} << e_ord) >= 32'(req_reg) &&
                        (!found_reg || e_ord < pord_reg)) begin
                        found_next = 1'b1;
                        pick_next  = rd_addr_q_reg;
                        pord_next  = e_ord;
                    end
                    idx_next = idx_reg + 1'b1;
                    if ((AW+1)'(rd_addr_q_reg) + 1'b1 >= mem_size) begin
                        state_next = bafit_pkg::S_SCAN_END;
                    end
                end else begin
                    if (e_start && !e_free && e_tag == tag_reg) begin
                        found_next = 1'b1;
                        cur_next   = rd_addr_q_reg;
                        cord_next  = e_ord;
                        we         = 1'b1;
                        waddr      = rd_addr_q_reg;
                        wdata      = {{TW{1'b0}}, e_ord, 2'b11};
                        st_next    = bafit_pkg::ST_OK;
                        off_next   = 6'(rd_addr_q_reg);
                        sz_next    = 7'(32'd1 << e_ord);
                        state_next = bafit_pkg::S_MERGE_RD;
                    end else if ((AW+1)'(rd_addr_q_reg) + 1'b1 >= mem_size) begin
                        st_next    = bafit_pkg::ST_NO_TAG;
                        off_next   = '0;
                        sz_next    = '0;
                        state_next = bafit_pkg::S_OUT;
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            bafit_pkg::S_SCAN_END: begin
                if (!found_reg) begin
                    st_next    = bafit_pkg::ST_NO_FIT;
                    off_next   = '0;
                    sz_next    = '0;
                    state_next = bafit_pkg::S_OUT;
                end else begin
                    state_next = bafit_pkg::S_SPLIT;
                end
            end
            bafit_pkg::S_SPLIT: begin
                // One halving per cycle; the upper half becomes a free block.
                half = (AW+1)'((AW+1)'(1) << pord_reg) >> 1;
                if (pord_reg != '0 && 32'(half) >= 32'(req_reg)) begin
                    we        = 1'b1;
                    waddr     = pick_reg + half[AW-1:0];
                    wdata     = {{TW{1'b0}}, pord_reg - 1'b1, 2'b11};
                    pord_next = pord_reg - 1'b1;
                end else begin
                    we         = 1'b1;
                    waddr      = pick_reg;
                    wdata      = {tag_reg, pord_reg, 2'b01};
                    st_next    = bafit_pkg::ST_OK;
                    off_next   = 6'(pick_reg);
                    sz_next    = 7'(32'd1 << pord_reg);
                    state_next = bafit_pkg::S_OUT;
                end
            end
            bafit_pkg::S_MERGE_RD: begin
                bud   = cur_reg ^ AW'((AW+1)'(1) << cord_reg);
                raddr = bud;
                if (cord_reg >= ord_eff) begin
                    state_next = bafit_pkg::S_OUT;
                end else begin
                    state_next = bafit_pkg::S_MERGE_CHK;
                end
            end
            bafit_pkg::S_MERGE_CHK: begin
                bud = cur_reg ^ AW'((AW+1)'(1) << cord_reg);
                if (e_start && e_free && e_ord == cord_reg) begin
                    // Clear the upper block and grow the lower one.
                    we    = 1'b1;
                    waddr = (cur_reg < bud) ? bud : cur_reg;
                    wdata = '0;
                    cur_next   = (cur_reg < bud) ? cur_reg : bud;
                    cord_next  = cord_reg + 1'b1;
                    state_next = bafit_pkg::S_MERGE_RD;
                end else begin
                    we    = 1'b1;
                    waddr = cur_reg;
                    wdata = {{TW{1'b0}}, cord_reg, 2'b11};
                    state_next = bafit_pkg::S_OUT;
                end
            end
            bafit_pkg::S_OUT: begin
                if (mvalid_reg && m_tready) begin
                    state_next = bafit_pkg::S_IDLE;
                end
            end
            default: state_next = bafit_pkg::S_IDLE;
        endcase
        // The surviving lower block of a merge is rewritten on the way back.
        if (state_reg == bafit_pkg::S_MERGE_RD && cord_reg >= ord_eff) begin
            we    = 1'b1;
            waddr = cur_reg;
            wdata = {{TW{1'b0}}, cord_reg, 2'b11};
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bafit_pkg::S_CLEAR;
            order_cfg_reg <= 3'd6;
            idx_reg       <= '0;
            mvalid_reg    <= 1'b0;
            found_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                order_cfg_reg <= cfg_wdata;
                state_reg     <= bafit_pkg::S_CLEAR;
                idx_reg       <= '0;
            end else begin
                state_reg <= state_next;
                idx_reg   <= idx_next;
            end
            found_reg <= found_next;
            if (mvalid_reg && m_tready) begin
                mvalid_reg <= 1'b0;
            end else if (state_reg != bafit_pkg::S_OUT && state_next == bafit_pkg::S_OUT) begin
                mvalid_reg <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        pick_reg      <= pick_next;
        pord_reg      <= pord_next;
        cur_reg       <= cur_next;
        cord_reg      <= cord_next;
        st_reg        <= st_next;
        off_reg       <= off_next;
        sz_reg        <= sz_next;
        rd_addr_q_reg <= raddr;
        if (s_tvalid && s_tready) begin
            op_reg  <= s_tdata[0];
            tag_reg <= TW'(s_tdata[8:1]);
            req_reg <= s_tdata[15:9];
        end
    end

    `ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, state_reg != bafit_pkg::S_IDLE, !s_tready)
    `ASSERT_IMPL(a_valid_in_out, aclk, aresetn, mvalid_reg, state_reg == bafit_pkg::S_OUT)
    `ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, s_tvalid && s_tready,
                 state_reg != bafit_pkg::S_IDLE)

endmodule

FILE: design/bafit_ram.sv
module bafit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sim/buddy_allocator_best_fit_checker.sv
module buddy_allocator_best_fit_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    output int          fail_count,
    output int          pending_count
);

    // One table entry per unit offset, as the block keeps it.
    typedef struct packed {
        logic       start;
        logic       free;
        logic [2:0] order;
        logic [7:0] tag;
    } blk_entry_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] offset;
        logic [6:0] size;
    } grant_t;

    blk_entry_t blk_map [64];
    logic [2:0] mem_order;
    grant_t     grants_due [$];

    // The usable order never exceeds six for 64 units.
    function automatic logic [2:0] live_order();
        return (mem_order > 3'd6) ? 3'd6 : mem_order;
    endfunction

    task automatic wipe_map();
        for (int i = 0; i < 64; i++) blk_map[i] = '0;
        blk_map[0].start = 1'b1;
        blk_map[0].free  = 1'b1;
        blk_map[0].order = live_order();
    endtask

    task automatic allocate(input logic [7:0] tag, input logic [6:0] req, output grant_t g);
        int mem;
        int pick;
        int half;
        bit found;
        mem = 1 << live_order();
        pick = 0;
        found = 0;
        g = '0;
        if (req == 0) begin
            g.status = bafit_pkg::ST_BAD_SIZE;
            return;
        end
        for (int i = 0; i < mem; i++) begin
            if (blk_map[i].start && blk_map[i].free && (1 << blk_map[i].order) >= req) begin
                if (!found || blk_map[i].order < blk_map[pick].order) begin
                    pick = i;
                    found = 1;
                end
            end
        end
        if (!found) begin
            g.status = bafit_pkg::ST_NO_FIT;
            return;
        end
        // Halve while the lower half still holds the request.
        while (blk_map[pick].order > 0) begin
            half = 1 << (blk_map[pick].order - 1);
            if (half < req) break;
            blk_map[pick].order = blk_map[pick].order - 1;
            blk_map[pick + half].start = 1'b1;
            blk_map[pick + half].free  = 1'b1;
            blk_map[pick + half].order = blk_map[pick].order;
            blk_map[pick + half].tag   = '0;
        end
        blk_map[pick].free = 1'b0;
        blk_map[pick].tag  = tag;
        g.status = bafit_pkg::ST_OK;
        g.offset = pick[5:0];
        g.size   = 7'(1 << blk_map[pick].order);
    endtask

    task automatic release_tag(input logic [7:0] tag, output grant_t g);
        int mem;
        int idx;
        int cur;
        int bud;
        int lo;
        int hi;
        mem = 1 << live_order();
        idx = -1;
        g = '0;
        for (int i = 0; i < mem; i++) begin
            if (idx < 0 && blk_map[i].start && !blk_map[i].free && blk_map[i].tag == tag)
                idx = i;
        end
        if (idx < 0) begin
            g.status = bafit_pkg::ST_NO_TAG;
            return;
        end
        // The reported size is the one before any merging.
        g.status = bafit_pkg::ST_OK;
        g.offset = idx[5:0];
        g.size   = 7'(1 << blk_map[idx].order);
        blk_map[idx].free = 1'b1;
        blk_map[idx].tag  = '0;
        cur = idx;
        while (blk_map[cur].order < live_order()) begin
            bud = cur ^ (1 << blk_map[cur].order);
            if (bud >= mem || !blk_map[bud].start || !blk_map[bud].free ||
                blk_map[bud].order != blk_map[cur].order) break;
            lo = (cur < bud) ? cur : bud;
            hi = (cur < bud) ? bud : cur;
            blk_map[hi] = '0;
            blk_map[lo].order = blk_map[lo].order + 1;
            cur = lo;
        end
    endtask

    task automatic report(input string what, input grant_t got, input grant_t want);
        $display("mismatch (%s): got st=%0d off=%0d sz=%0d, want st=%0d off=%0d sz=%0d",
                 what, got.status, got.offset, got.size, want.status, want.offset, want.size);
        fail_count++;
    endtask

    assign pending_count = grants_due.size();

    // Predict on each accepted request, compare on each accepted result.
    always @(posedge aclk) begin
        grant_t g;
        grant_t got;
        grant_t want;
        if (!aresetn) begin
            mem_order = 3'd6;
            wipe_map();
            grants_due.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) begin
                mem_order = cfg_wdata;
                wipe_map();
            end
            if (s_tvalid && s_tready) begin
                if (s_tdata[0] == bafit_pkg::OP_ALLOC) allocate(s_tdata[8:1], s_tdata[15:9], g);
                else release_tag(s_tdata[8:1], g);
                grants_due.push_back(g);
            end
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[1:0], m_tdata[7:2], m_tdata[14:8]};
                if (grants_due.size() == 0) begin
                    report("unexpected result", got, '0);
                end else begin
                    want = grants_due.pop_front();
                    if (got.status != want.status) report("status", got, want);
                    else if (got.offset != want.offset) report("block_offset", got, want);
                    else if (got.size != want.size) report("block_size", got, want);
                end
            end
        end
    end

endmodule

FILE: sim/buddy_allocator_best_fit_tb.sv
module buddy_allocator_best_fit_tb;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;    // operation[0], tag[8:1], request_size[15:9]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // status[1:0], block_offset[7:2], block_size[14:8]
    int          fail_count;
    int          pending_count;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          recv_hold = 1'b0;
    int          quiet_cycles = 0;
    logic [7:0]  live_tags [$];

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    buddy_allocator_best_fit dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    buddy_allocator_best_fit_checker chk (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // Result side back-pressure, random or held off entirely.
    always @(posedge aclk) begin
        m_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles with no request or result accepted.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[buddy_allocator_best_fit] ERROR");
            $finish;
        end
    end

    // The request is dropped only after an edge at which s_tready is seen high, so valid
    // never gets two updates in one step.
    task automatic send_request(input logic op, input logic [7:0] tag, input logic [6:0] sz);
        while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {sz, tag, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (pending_count != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_order(input logic [2:0] ord);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= ord;
        @(posedge aclk);
        cfg_we <= 1'b0;
        live_tags.delete();
    endtask

    // Mostly well-formed: allocations of small sizes, releases of known tags.
    task automatic random_request();
        logic [7:0] tag;
        int k;
        if ($urandom_range(99) < 55 || live_tags.size() == 0) begin
            tag = (live_tags.size() > 0 && $urandom_range(9) == 0) ?
                  live_tags[$urandom_range(live_tags.size() - 1)] : 8'($urandom);
            live_tags.push_back(tag);
            case ($urandom_range(9))
                0: send_request(bafit_pkg::OP_ALLOC, tag, 7'($urandom));
                1: send_request(bafit_pkg::OP_ALLOC, tag, 7'($urandom_range(64)));
                default: send_request(bafit_pkg::OP_ALLOC, tag, 7'($urandom_range(1, 8)));
            endcase
        end else if ($urandom_range(9) == 0) begin
            send_request(bafit_pkg::OP_RELEASE, 8'($urandom), 7'($urandom));
        end else begin
            k = $urandom_range(live_tags.size() - 1);
            tag = live_tags[k];
            live_tags.delete(k);
            send_request(bafit_pkg::OP_RELEASE, tag, 7'($urandom));
        end
    endtask

    initial begin
        int phase_pct [4][2] = '{'{0, 0}, '{73, 0}, '{0, 73}, '{24, 24}};
        logic [2:0] orders [5] = '{3'd6, 3'd7, 3'd3, 3'd0, 3'd5};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed: extremes, zero size, oversize, unknown tag, merges.
        send_request(bafit_pkg::OP_ALLOC, 8'h00, 7'd0);
        send_request(bafit_pkg::OP_ALLOC, 8'hFF, 7'd127);
        send_request(bafit_pkg::OP_ALLOC, 8'hFF, 7'd65);
        send_request(bafit_pkg::OP_RELEASE, 8'h42, 7'd0);
        send_request(bafit_pkg::OP_ALLOC, 8'hFF, 7'd64);
        send_request(bafit_pkg::OP_ALLOC, 8'h01, 7'd1);
        send_request(bafit_pkg::OP_RELEASE, 8'hFF, 7'h7F);
        send_request(bafit_pkg::OP_ALLOC, 8'h01, 7'd1);
        send_request(bafit_pkg::OP_ALLOC, 8'h02, 7'd3);
        send_request(bafit_pkg::OP_ALLOC, 8'h03, 7'd33);
        send_request(bafit_pkg::OP_ALLOC, 8'h04, 7'd17);
        send_request(bafit_pkg::OP_RELEASE, 8'h01, 7'd0);
        send_request(bafit_pkg::OP_RELEASE, 8'h01, 7'd0);
        send_request(bafit_pkg::OP_RELEASE, 8'h02, 7'd0);
        send_request(bafit_pkg::OP_RELEASE, 8'h04, 7'd0);
        send_request(bafit_pkg::OP_ALLOC, 8'hAA, 7'd64);
        send_request(bafit_pkg::OP_RELEASE, 8'hAA, 7'd0);
        write_order(3'd0);
        send_request(bafit_pkg::OP_ALLOC, 8'h55, 7'd2);
        send_request(bafit_pkg::OP_ALLOC, 8'h55, 7'd1);
        send_request(bafit_pkg::OP_RELEASE, 8'h55, 7'd1);

        // Random phases through several orders and idling profiles.
        for (int p = 0; p < 5; p++) begin
            write_order(orders[p]);
            for (int q = 0; q < 4; q++) begin
                send_idle_pct  = phase_pct[q][0];
                recv_stall_pct = phase_pct[q][1];
                repeat (55) random_request();
            end
        end

        // Long hold-off on results while requests keep coming.
        write_order(3'd6);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold = 1'b1;
        fork
            begin
                repeat (1500) @(posedge aclk);
                recv_hold = 1'b0;
            end
            repeat (10) random_request();
        join
        // Sender pauses until every result is back, then continues.
        drain();
        repeat (10) random_request();

        drain();
        if (fail_count == 0) begin
            $display("[buddy_allocator_best_fit] OK");
        end else begin
            $display("[buddy_allocator_best_fit] ERROR");
        end
        $finish;
    end

endmodule
